// ===== hw/rtl/adadelta_parameter_update_macros.svh =====
// Assertion macros for the parameter update block.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ADADELTA_PARAMETER_UPDATE_MACROS_SVH
`define ADADELTA_PARAMETER_UPDATE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on the rising clock, off during reset.
`define AD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on the rising clock, also during reset.
`define AD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define AD_ASSERT(lbl, clk, rst_n, prop, msg)
`define AD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/adadelta_pkg.sv =====
// Types and constants of the parameter update block.
// No dependencies.
`timescale 1ns / 1ps
package adadelta_pkg;

    localparam logic [15:0] DECAY_RESET = 16'd62259;
    localparam logic [15:0] EPS_RESET   = 16'd1;

    // Configuration register indexes
    localparam logic CFG_DECAY = 1'b0;
    localparam logic CFG_EPS   = 1'b1;

    // Item operations
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [47:0] MAX48 = {48{1'b1}};
    localparam logic [31:0] MAX32 = {32{1'b1}};

    typedef struct packed {
        logic              op;
        logic [9:0]        index;
        logic signed [31:0] value;
    } t_in_req;

    typedef struct packed {
        logic [9:0]        out_index;
        logic signed [31:0] param_value;
        logic              saturated;
    } t_out_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LATCH,
        ST_SQ,
        ST_SQC,
        ST_FA,
        ST_FB,
        ST_FC,
        ST_FD,
        ST_FE,
        ST_ROOT_INIT,
        ST_ROOT_RUN,
        ST_DMUL,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_UPD,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/adadelta_parameter_update.sv =====
// Top level of the AdaDelta parameter update block.
// Depends on adadelta_pkg, adadelta_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "adadelta_parameter_update_macros.svh"
// A table of NUM_PARAMS Q16.16 parameters, each with decayed mean squares of
// its gradients and its steps, kept in one RAM. A load request writes a value
// and clears the entry's accumulators; an update request applies one AdaDelta
// step and returns the new parameter. Requests are taken one at a time. Each
// square root of an update runs R one-bit steps, where R = (34 + FRAC_BITS)
// / 2 rounded down. An update uses one shared 32x32 multiplier nine times
// and one shared shift-subtract unit that runs two roots and a 32-step
// division. A finished result waits in an output register, so the next
// request is taken while it is stalled. No clearing pass follows reset; an
// entry must be loaded first.
module adadelta_parameter_update
    import adadelta_pkg::*;
#(
    parameter int NUM_PARAMS = 1024,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_req    o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int ADDR_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam int RAD_W  = 2 * ((34 + FRAC_BITS) / 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 4;
    localparam int CNT_W  = 6;
    localparam int ENT_W  = 96;

    t_state r_state, n_state;

    t_in_req  r_req;
    t_out_req r_out;
    logic     r_ovalid;
    logic     r_inrange;
    logic     r_sat;
    logic     r_second;
    logic     r_root_sel;

    logic [15:0] r_decay, r_eps;

    logic signed [31:0] r_param;
    logic [31:0]        r_g_acc, r_s_acc;
    logic [47:0]        r_sq;
    logic [63:0]        r_prod;
    logic [65:0]        r_mac;
    logic [ROOT_W-1:0]  r_rg, r_ru;
    logic [31:0]        r_smag;

    logic [REM_W-1:0] r_rem;
    logic [RAD_W-1:0] r_src;
    logic [31:0]      r_res;
    logic [CNT_W-1:0] r_cnt;

    logic [31:0]       mul_a, mul_b;
    logic              ram_we;
    logic [ENT_W-1:0]  ram_rdata;
    logic              out_free;
    logic              accept;
    logic              gneg;
    logic [31:0]       gmag;
    logic [16:0]       inv;
    logic              div_mode;
    logic [REM_W-1:0]  shifted, trial, step_rem;
    logic              ge;
    logic [31:0]       n_res;
    logic [32:0]       rad_sum;
    logic [63:0]       sq_full;
    logic [49:0]       fold_t;
    logic signed [33:0] p_sum;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign gneg     = r_req.value[31];
    assign gmag     = gneg ? (32'd0 - r_req.value) : r_req.value;
    assign inv      = 17'h10000 - {1'b0, r_decay};

    // Shared shift-subtract step for square root and division
    assign div_mode = (r_state == ST_DIV_RUN);
    always_comb begin
        if (div_mode) begin
            shifted = {r_rem[REM_W-2:0], r_src[RAD_W-1]};
            trial   = REM_W'(r_rg);
        end else begin
            shifted = {r_rem[REM_W-3:0], r_src[RAD_W-1 -: 2]};
            trial   = REM_W'({r_res[ROOT_W-1:0], 2'b01});
        end
        ge       = (shifted >= trial);
        step_rem = ge ? (shifted - trial) : shifted;
        n_res    = {r_res[30:0], ge};
    end

    // Side arithmetic of single states
    assign rad_sum = {1'b0, (r_root_sel ? r_s_acc : r_g_acc)} + 33'(r_eps);
    assign sq_full = r_prod >> FRAC_BITS;
    assign fold_t  = r_mac[65:16];
    assign p_sum   = 34'(r_param) + (gneg ? $signed({2'b00, r_smag})
                                          : -$signed({2'b00, r_smag}));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_LATCH;
            end
            ST_LATCH: begin
                if (!r_inrange || r_req.op == OP_LOAD) n_state = ST_DONE;
                else n_state = ST_SQ;
            end
            ST_SQ:   n_state = ST_SQC;
            ST_SQC:  n_state = ST_FA;
            ST_FA:   n_state = ST_FB;
            ST_FB:   n_state = ST_FC;
            ST_FC:   n_state = ST_FD;
            ST_FD:   n_state = ST_FE;
            ST_FE:   n_state = r_second ? ST_UPD : ST_ROOT_INIT;
            ST_ROOT_INIT: n_state = ST_ROOT_RUN;
            ST_ROOT_RUN: begin
                if (r_cnt == CNT_W'(1)) n_state = r_root_sel ? ST_DMUL : ST_ROOT_INIT;
            end
            ST_DMUL: n_state = ST_DIV_INIT;
            ST_DIV_INIT: begin
                if (r_rg == '0 || r_prod[63:32] >= 32'(r_rg)) n_state = ST_SQ;
                else n_state = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (r_cnt == CNT_W'(1)) n_state = ST_SQ;
            end
            ST_UPD:  n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs: multiplier operands, request stall, table write
    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        o_in_stall = 1'b1;
        ram_we     = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_SQ: begin
                mul_a = r_second ? r_smag : gmag;
                mul_b = r_second ? r_smag : gmag;
            end
            ST_FA: begin
                mul_a = 32'(r_decay);
                mul_b = r_second ? r_s_acc : r_g_acc;
            end
            ST_FB: begin
                mul_a = 32'(inv);
                mul_b = r_sq[31:0];
            end
            ST_FC: begin
                mul_a = 32'(inv);
                mul_b = 32'(r_sq[47:32]);
            end
            ST_DMUL: begin
                mul_a = 32'(r_ru);
                mul_b = gmag;
            end
            ST_DONE: ram_we = out_free && r_inrange;
            default: ;
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_decay  <= DECAY_RESET;
            r_eps    <= EPS_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DECAY: r_decay <= i_cfg_data;
                    CFG_EPS:   r_eps   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_DONE && out_free) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_req     <= i_in;
                    r_inrange <= (32'(i_in.index) < 32'(NUM_PARAMS));
                    r_sat     <= 1'b0;
                    r_second  <= 1'b0;
                    r_root_sel <= 1'b0;
                end
            end
            ST_LATCH: begin
                if (!r_inrange) begin
                    r_param <= '0;
                end else if (r_req.op == OP_LOAD) begin
                    r_param <= r_req.value;
                    r_g_acc <= '0;
                    r_s_acc <= '0;
                end else begin
                    r_param <= ram_rdata[95:64];
                    r_g_acc <= ram_rdata[63:32];
                    r_s_acc <= ram_rdata[31:0];
                end
            end
            ST_SQC: begin
                if (sq_full[63:48] != '0) begin
                    r_sq  <= MAX48;
                    r_sat <= 1'b1;
                end else begin
                    r_sq <= sq_full[47:0];
                end
            end
            ST_FB: r_mac <= 66'(r_prod);
            ST_FC: r_mac <= r_mac + 66'(r_prod);
            ST_FD: r_mac <= r_mac + (66'(r_prod) << 32);
            ST_FE: begin
                if (fold_t[49:32] != '0) begin
                    r_sat <= 1'b1;
                    if (r_second) r_s_acc <= MAX32;
                    else r_g_acc <= MAX32;
                end else begin
                    if (r_second) r_s_acc <= fold_t[31:0];
                    else r_g_acc <= fold_t[31:0];
                end
            end
            ST_ROOT_INIT: begin
                r_rem <= '0;
                r_res <= '0;
                r_src <= RAD_W'(rad_sum) << FRAC_BITS;
                r_cnt <= CNT_W'(ROOT_W);
            end
            ST_ROOT_RUN: begin
                r_rem <= step_rem;
                r_res <= n_res;
                r_src <= r_src << 2;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    if (r_root_sel) r_ru <= n_res[ROOT_W-1:0];
                    else r_rg <= n_res[ROOT_W-1:0];
                    r_root_sel <= 1'b1;
                end
            end
            ST_DIV_INIT: begin
                r_second <= 1'b1;
                r_rem    <= REM_W'(r_prod[63:32]);
                r_res    <= '0;
                r_src    <= RAD_W'(r_prod[31:0]) << (RAD_W - 32);
                r_cnt    <= CNT_W'(32);
                if (r_rg == '0) begin
                    r_smag <= '0;
                end else if (r_prod[63:32] >= 32'(r_rg)) begin
                    r_smag <= MAX32;
                    r_sat  <= 1'b1;
                end
            end
            ST_DIV_RUN: begin
                r_rem <= step_rem;
                r_res <= n_res;
                r_src <= r_src << 1;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) r_smag <= n_res;
            end
            ST_UPD: begin
                if (p_sum > 34'sd2147483647) begin
                    r_param <= 32'h7FFF_FFFF;
                    r_sat   <= 1'b1;
                end else if (p_sum < -34'sd2147483648) begin
                    r_param <= 32'h8000_0000;
                    r_sat   <= 1'b1;
                end else begin
                    r_param <= p_sum[31:0];
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out.out_index   <= r_req.index;
                    r_out.param_value <= r_param;
                    r_out.saturated   <= r_sat && r_inrange && (r_req.op == OP_UPDATE);
                end
            end
            default: ;
        endcase
    end

    // Parameter table: parameter, gradient mean square, step mean square
    adadelta_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_PARAMS),
        .ADDR_W(ADDR_W)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ADDR_W'(r_req.index)),
        .i_wdata({r_param, r_g_acc, r_s_acc}),
        .i_raddr(ADDR_W'(i_in.index)),
        .o_rdata(ram_rdata)
    );

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // Checks
    `AD_ASSERT(a_busy_after_accept, i_clk, i_rst_n, accept |=> o_in_stall, "accepted request not held off")
    `AD_ASSERT(a_result_from_done, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state == ST_DONE), "result not from done state")
    `AD_ASSERT(a_div_count, i_clk, i_rst_n, (r_state == ST_DIV_RUN) |-> (r_cnt <= CNT_W'(32) && r_cnt != '0), "division step count out of range")
    `AD_ASSERT(a_zero_root_step, i_clk, i_rst_n, (r_state == ST_UPD && r_rg == '0) |-> (r_smag == '0), "nonzero step with zero gradient root")

endmodule

// ===== hw/rtl/adadelta_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module adadelta_ram #(
    parameter int WIDTH  = 96,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/adadelta_parameter_update_test.sv =====
// Self-checking test of the AdaDelta parameter update block.
// Depends on adadelta_pkg and adadelta_parameter_update; predicts each result in place.
`timescale 1ns / 1ps
module adadelta_parameter_update_test;
    import adadelta_pkg::*;

    localparam int CYCLE_LIMIT = 20000;
    localparam int FB = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_req     i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_req    o_out;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    adadelta_parameter_update uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predictor state
    logic [31:0] param_tbl [1024];
    logic [31:0] grad_tbl [1024];
    logic [31:0] step_tbl [1024];
    bit          loaded [1024];
    logic [15:0] rho;
    logic [15:0] eps;
    t_out_req    expected_q [$];
    int          mismatches;
    int          idle_cycles;
    int          hold_off;
    bit          gaps_on;
    bit          done;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] square_q(logic [63:0] mag, ref bit sat);
        logic [63:0] s;
        s = (mag * mag) >> FB;
        if (s > {16'd0, MAX48}) begin
            s = {16'd0, MAX48};
            sat = 1'b1;
        end
        return s;
    endfunction

    // Fold a square into a decayed mean; the full product needs 81 bits.
    function automatic logic [31:0] decay_fold(logic [31:0] acc, logic [63:0] sq,
                                               ref bit sat);
        logic [95:0] t;
        t = ({80'd0, rho} * {64'd0, acc}
             + ({79'd0, 17'h10000 - {1'b0, rho}}) * {32'd0, sq}) >> 16;
        if (t > {64'd0, MAX32}) begin
            t = {64'd0, MAX32};
            sat = 1'b1;
        end
        return t[31:0];
    endfunction

    function automatic logic [63:0] rms_of(logic [31:0] acc);
        return isqrt(({32'd0, acc} + {48'd0, eps}) << FB);
    endfunction

    // Apply one request to the predictor and return the expected result.
    function automatic t_out_req predict_update(t_in_req r);
        t_out_req res;
        bit sat;
        bit gneg;
        logic [63:0] gmag, rg, ru, smag;
        logic [127:0] prod;
        longint p;
        sat = 1'b0;
        res.out_index = r.index;
        res.param_value = 0;
        res.saturated = 1'b0;
        if (r.op == OP_LOAD) begin
            param_tbl[r.index] = r.value;
            grad_tbl[r.index] = 0;
            step_tbl[r.index] = 0;
            loaded[r.index] = 1'b1;
            res.param_value = r.value;
            return res;
        end
        gneg = r.value[31];
        gmag = gneg ? (64'd1 << 32) - {32'd0, r.value} : {32'd0, r.value};
        grad_tbl[r.index] = decay_fold(grad_tbl[r.index], square_q(gmag, sat), sat);
        rg = rms_of(grad_tbl[r.index]);
        ru = rms_of(step_tbl[r.index]);
        smag = 0;
        if (rg != 0) begin
            prod = ({64'd0, ru} * {64'd0, gmag}) / {64'd0, rg};
            if (prod > {96'd0, MAX32}) begin
                prod = {96'd0, MAX32};
                sat = 1'b1;
            end
            smag = prod[63:0];
        end
        step_tbl[r.index] = decay_fold(step_tbl[r.index], square_q(smag, sat), sat);
        p = longint'($signed(param_tbl[r.index]));
        p = gneg ? p + longint'(smag) : p - longint'(smag);
        if (p > 64'sd2147483647) begin
            p = 64'sd2147483647;
            sat = 1'b1;
        end else if (p < -64'sd2147483648) begin
            p = -64'sd2147483648;
            sat = 1'b1;
        end
        param_tbl[r.index] = p[31:0];
        res.param_value = p[31:0];
        res.saturated = sat;
        return res;
    endfunction

    // Receiver: random stalls, optional long hold-off, compare on accept.
    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %p", o_out);
            end else begin
                want = expected_q.pop_front();
                if (o_out !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", want, o_out);
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= gaps_on ? ($urandom_range(99) < 35) : 1'b0;
        end
    end

    // Watchdog on cycles with no accepted request either way.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one request until accepted, with random idle cycles first.
    task automatic send_request(logic op, logic [9:0] idx, logic [31:0] val);
        t_in_req r;
        r.op = op;
        r.index = idx;
        r.value = val;
        while (gaps_on && $urandom_range(99) < 35) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_q.push_back(predict_update(r));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DECAY) rho = data;
        else eps = data;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h0002_0000);
            2: return -$urandom_range(32'h0002_0000);
            default: return {{16{1'b0}}, 16'($urandom)};
        endcase
    endfunction

    function automatic logic [9:0] loaded_index();
        logic [9:0] i;
        do i = 10'($urandom_range(15) * 64 + $urandom_range(63)); while (!loaded[i]);
        return i;
    endfunction

    // Extremes of value, reset configuration, index extremes.
    task automatic test_directed();
        send_request(OP_LOAD, 10'd0, 32'h7FFF_FFFF);
        send_request(OP_LOAD, 10'd1023, 32'h8000_0000);
        send_request(OP_LOAD, 10'd5, 32'h0001_0000);
        send_request(OP_UPDATE, 10'd0, 32'h8000_0000);
        send_request(OP_UPDATE, 10'd0, 32'h7FFF_FFFF);
        send_request(OP_UPDATE, 10'd1023, 32'h7FFF_FFFF);
        send_request(OP_UPDATE, 10'd1023, 32'h8000_0000);
        send_request(OP_UPDATE, 10'd5, 32'h0000_0000);
        send_request(OP_UPDATE, 10'd5, 32'hFFFF_FFFF);
        send_request(OP_UPDATE, 10'd5, 32'h0000_0001);
        send_request(OP_UPDATE, 10'd5, 32'h0001_0000);
        drain();
    endtask

    // Configuration extremes with a few updates each.
    task automatic test_config_extremes();
        logic [15:0] rhos [3] = '{16'd0, 16'd65535, 16'd32768};
        logic [15:0] epss [3] = '{16'd65535, 16'd1, 16'd300};
        for (int k = 0; k < 3; k++) begin
            write_reg(CFG_DECAY, rhos[k]);
            write_reg(CFG_EPS, epss[k]);
            send_request(OP_LOAD, 10'd7, 32'h0000_8000);
            send_request(OP_UPDATE, 10'd7, 32'hFFF0_0000);
            send_request(OP_UPDATE, 10'd7, 32'h7FFF_FFFF);
            send_request(OP_UPDATE, 10'd7, 32'h0000_4000);
            drain();
        end
        write_reg(CFG_DECAY, DECAY_RESET);
        write_reg(CFG_EPS, EPS_RESET);
    endtask

    // Receiver holds off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        hold_off = 400;
        for (int k = 0; k < 6; k++)
            send_request(k % 2 ? OP_UPDATE : OP_LOAD, 10'd9, rand_value());
        drain();
    endtask

    // Random phases of mixed loads and updates, with config changed between phases.
    task automatic test_random(int count);
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_reg(CFG_DECAY, 16'($urandom));
                write_reg(CFG_EPS, 16'($urandom_range(65535, 1)));
            end
            gaps_on = (ph != 2);
            for (int k = 0; k < count / 6; k++) begin
                if ($urandom_range(9) == 0 || !loaded[k % 1024])
                    send_request(OP_LOAD, 10'($urandom), rand_value());
                else
                    send_request(OP_UPDATE, loaded_index(), rand_value());
            end
            drain();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_DECAY;
        i_cfg_data = '0;
        rho = DECAY_RESET;
        eps = EPS_RESET;
        mismatches = 0;
        idle_cycles = 0;
        hold_off = 0;
        gaps_on = 1'b1;
        done = 1'b0;
        for (int i = 0; i < 1024; i++) loaded[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random(1000);
        done = 1'b1;
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
